/* hdl/hbrc_pkg.sv */
// Shared types and constants for the hashed bucket run counter.
`default_nettype none
package hbrc_pkg;

    localparam logic [31:0] FIB_LO  = 32'h7F4A7C15;
    localparam logic [31:0] FIB_HI  = 32'h9E3779B9;
    localparam logic [31:0] CNT_MAX = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        KIND_COUNTED = 2'd0,
        KIND_SPILLED = 2'd1,
        KIND_DRAINED = 2'd2,
        KIND_EMPTY   = 2'd3
    } t_kind;

    // sequencer to datapath
    typedef struct packed {
        logic accept;  // latch input word, update pending run
        logic clr;     // clearing sweep step
        logic mul0;    // key lo * mult lo
        logic mul1;    // key hi * mult lo
        logic mul2;    // key lo * mult hi
        logic hash;    // form bucket index
        logic rd;      // read bucket row
        logic upd;     // write back row, emit run word
        logic dmask;   // load occupancy of drained row
        logic demit;   // emit one drain word
        logic sel;     // 0 old run, 1 run closed by end of data
        logic last;    // last flag for run word
    } t_cmd;

    // datapath to sequencer
    typedef struct packed {
        logic is_drain;
        logic has_old;
        logic has_eod;
        logic out_busy;
        logic drn_last;
        logic clr_last;
    } t_sts;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? CNT_MAX : s[31:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/hashed_bucket_run_counter_core.sv */
// Top level of the hashed bucket run counter: sequencer plus datapath.
// Each closed run steps through accept, three 32x32 products on one shared
// multiplier, hash, row read and row write-back; an end-of-data key that
// closes two runs takes these steps after accept once for each run.
// A drain reads the row, loads its occupancy and lists one way per cycle
// while the output is not stalled. After reset a clearing pass zeroes the
// way counts of every bucket, taking no word but taking configuration writes.
`default_nettype none
module hashed_bucket_run_counter_core
    import hbrc_pkg::*;
#(
    parameter int BUCKETS = 1024,  // power of two
    parameter int WAYS    = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wen,
    input  wire  [3:0]   i_cfg_wdata,    // index_bits
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [79:0]  s_axis_tdata,   // key[63:0], bucket_index[73:64], zero pad
    input  wire  [0:0]   s_axis_tuser,   // req_type
    input  wire          s_axis_tlast,   // end_of_data
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata,   // out_key, bucket, slot, hit, run_length,
                                         // count, zero pad
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);

    t_cmd cmd;
    t_sts sts;

    logic [1:0]  kind;
    logic [63:0] okey;
    logic [9:0]  bucket;
    logic [1:0]  slot;
    logic        hit;
    logic [31:0] run, count;

    hbrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (s_axis_tready)
    );

    hbrc_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (s_axis_tuser[0]),
        .i_key       (s_axis_tdata[63:0]),
        .i_eod       (s_axis_tlast),
        .i_bidx      (s_axis_tdata[73:64]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (kind),
        .o_key       (okey),
        .o_bucket    (bucket),
        .o_slot      (slot),
        .o_hit       (hit),
        .o_run       (run),
        .o_count     (count),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {3'd0, count, run, hit, slot, bucket, okey};

    // no input word while the clearing pass runs
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !s_axis_tready) else $error("input taken during clear");

    // a new output word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.upd || cmd.demit) |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("output word overwritten");

    // an empty bucket answer is always the only word of its drain
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_EMPTY) |-> m_axis_tlast)
        else $error("empty word without last");

    // a spilled run carries no count
    a_spill_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SPILLED) |-> (count == 32'd0))
        else $error("spilled run with count");

endmodule
`default_nettype wire

/* hdl/hbrc_ctrl.sv */
// Sequencer for the hashed bucket run counter.
`default_nettype none
module hbrc_ctrl
    import hbrc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_M0, S_M1, S_M2, S_HASH, S_RD, S_UPD,
        S_DRD, S_DMASK, S_DEMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_second, n_second;

    always_comb begin
        o_cmd    = '0;
        o_cmd.sel  = r_sel;
        o_cmd.last = !r_second;
        n_state  = r_state;
        n_sel    = r_sel;
        n_second = r_second;
        o_ready  = (r_state == S_IDLE);
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_drain) begin
                        n_state = S_DRD;
                    end else if (i_sts.has_old) begin
                        n_sel    = 1'b0;
                        n_second = i_sts.has_eod;
                        n_state  = S_M0;
                    end else if (i_sts.has_eod) begin
                        n_sel    = 1'b1;
                        n_second = 1'b0;
                        n_state  = S_M0;
                    end
                end
            end
            S_M0:   begin o_cmd.mul0 = 1'b1; n_state = S_M1; end
            S_M1:   begin o_cmd.mul1 = 1'b1; n_state = S_M2; end
            S_M2:   begin o_cmd.mul2 = 1'b1; n_state = S_HASH; end
            S_HASH: begin o_cmd.hash = 1'b1; n_state = S_RD; end
            S_RD:   begin o_cmd.rd = 1'b1; n_state = S_UPD; end
            S_UPD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.upd = 1'b1;
                    if (r_second) begin
                        n_sel    = 1'b1;
                        n_second = 1'b0;
                        n_state  = S_M0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRD:   begin o_cmd.rd = 1'b1; n_state = S_DMASK; end
            S_DMASK: begin o_cmd.dmask = 1'b1; n_state = S_DEMIT; end
            S_DEMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.demit = 1'b1;
                    if (i_sts.drn_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_sel    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_second <= n_second;
        end
    end

endmodule
`default_nettype wire

/* hdl/hbrc_dp.sv */
// Datapath: pending run, hash multiplier, bucket memory, output word register.
`default_nettype none
module hbrc_dp
    import hbrc_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire         i_cfg_wen,
    input  wire  [3:0]  i_cfg_wdata,
    input  wire         i_req,
    input  wire  [63:0] i_key,
    input  wire         i_eod,
    input  wire  [9:0]  i_bidx,
    input  wire         i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_kind,
    output logic [63:0] o_key,
    output logic [9:0]  o_bucket,
    output logic [1:0]  o_slot,
    output logic        o_hit,
    output logic [31:0] o_run,
    output logic [31:0] o_count,
    output logic        o_last
);

    localparam int AB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [4:0] LOG2B = 5'(AB);

    logic [WAYS-1:0][63:0] mem_key [BUCKETS];
    logic [WAYS-1:0][31:0] mem_cnt [BUCKETS];

    logic [3:0]  r_ibits;
    logic [63:0] r_pkey;
    logic [31:0] r_plen;
    logic        r_pval;
    logic [63:0] r_c0key, r_c1key;
    logic [31:0] r_c0len, r_c1len;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;
    logic [AB-1:0] r_bkt, r_caddr;
    logic [WAYS-1:0][63:0] r_rkey;
    logic [WAYS-1:0][31:0] r_rcnt;
    logic [WAYS-1:0] r_mask;

    // input side
    logic        rep;
    logic [31:0] newlen;
    logic [15:0] bidx_ext;
    assign rep      = r_pval && (r_pkey == i_key);
    assign newlen   = rep ? sat_add(r_plen, 32'd1) : 32'd1;
    assign bidx_ext = 16'(i_bidx);

    // hash multiplier, one 32x32 product a step
    logic [63:0] ck;
    logic [31:0] rl, ma, mb;
    logic [63:0] prod;
    assign ck = i_cmd.sel ? r_c1key : r_c0key;
    assign rl = i_cmd.sel ? r_c1len : r_c0len;
    always_comb begin
        ma = ck[31:0];
        mb = FIB_LO;
        if (i_cmd.mul1) ma = ck[63:32];
        if (i_cmd.mul2) mb = FIB_HI;
    end
    assign prod = ma * mb;

    logic [4:0]  eff;
    logic [5:0]  sh;
    logic [31:0] hi, hsh;
    always_comb begin
        eff = {1'b0, r_ibits};
        if (eff == 5'd0) eff = 5'd1;
        if (eff > LOG2B) eff = LOG2B;
        sh  = 6'd32 - {1'b0, eff};
        hi  = r_p0[63:32] + r_p1 + r_p2;
        hsh = hi >> sh;
    end

    // bucket update
    logic [WAYS-1:0] occ;
    logic            found_hit, found_emp;
    logic [WW-1:0]   wsel;
    logic [31:0]     upd_cnt;
    always_comb begin
        found_hit = 1'b0;
        found_emp = 1'b0;
        wsel      = '0;
        for (int w = 0; w < WAYS; w++) begin
            occ[w] = (r_rcnt[w] != 32'd0);
            if (!found_hit && occ[w] && r_rkey[w] == ck) begin
                found_hit = 1'b1;
                wsel      = WW'(w);
            end
        end
        if (!found_hit) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found_emp && !occ[w]) begin
                    found_emp = 1'b1;
                    wsel      = WW'(w);
                end
            end
        end
        upd_cnt = found_hit ? sat_add(r_rcnt[wsel], rl) : rl;
    end

    // drain pick: lowest remaining way
    logic [WW-1:0]   dsel;
    logic [WAYS-1:0] drem;
    always_comb begin
        dsel = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_mask[w]) dsel = WW'(w);
        end
        drem = r_mask;
        drem[dsel] = 1'b0;
    end

    assign o_sts.is_drain = i_req;
    assign o_sts.has_old  = r_pval && !rep;
    assign o_sts.has_eod  = i_eod;
    assign o_sts.out_busy = o_out_valid && !i_out_ready;
    assign o_sts.drn_last = (drem == '0);
    assign o_sts.clr_last = (r_caddr == AB'(BUCKETS - 1));

    // memories
    logic [WAYS-1:0][63:0] wkey;
    logic [WAYS-1:0][31:0] wcnt;
    always_comb begin
        wkey = r_rkey;
        wcnt = r_rcnt;
        wkey[wsel] = ck;
        wcnt[wsel] = upd_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) mem_cnt[r_caddr] <= '0;
        if (i_cmd.upd && (found_hit || found_emp)) begin
            mem_cnt[r_bkt] <= wcnt;
            mem_key[r_bkt] <= wkey;
        end
        if (i_cmd.rd) begin
            r_rcnt <= mem_cnt[r_bkt];
            r_rkey <= mem_key[r_bkt];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ibits     <= 4'd10;
            r_pval      <= 1'b0;
            r_pkey      <= '0;
            r_plen      <= '0;
            r_caddr     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) r_ibits <= i_cfg_wdata;
            if (i_cmd.clr) r_caddr <= r_caddr + AB'(1);
            if (i_cmd.accept && !i_req) begin
                r_pkey <= i_key;
                r_plen <= i_eod ? 32'd0 : newlen;
                r_pval <= !i_eod;
            end
            if (i_cmd.upd || i_cmd.demit) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c0key <= r_pkey;
            r_c0len <= r_plen;
            r_c1key <= i_key;
            r_c1len <= newlen;
            r_bkt   <= bidx_ext[AB-1:0];
        end
        if (i_cmd.mul0) r_p0 <= prod;
        if (i_cmd.mul1) r_p1 <= prod[31:0];
        if (i_cmd.mul2) r_p2 <= prod[31:0];
        if (i_cmd.hash) r_bkt <= hsh[AB-1:0];
        if (i_cmd.dmask) r_mask <= occ;
        if (i_cmd.demit) r_mask <= drem;
        if (i_cmd.upd) begin
            o_key    <= ck;
            o_bucket <= 10'(r_bkt);
            o_run    <= rl;
            o_last   <= i_cmd.last;
            if (found_hit || found_emp) begin
                o_kind  <= KIND_COUNTED;
                o_slot  <= 2'(wsel);
                o_hit   <= found_hit;
                o_count <= upd_cnt;
            end else begin
                o_kind  <= KIND_SPILLED;
                o_slot  <= 2'd0;
                o_hit   <= 1'b0;
                o_count <= 32'd0;
            end
        end
        if (i_cmd.demit) begin
            o_bucket <= 10'(r_bkt);
            o_hit    <= 1'b0;
            o_run    <= 32'd0;
            o_last   <= (drem == '0);
            if (r_mask == '0) begin
                o_kind  <= KIND_EMPTY;
                o_key   <= 64'd0;
                o_slot  <= 2'd0;
                o_count <= 32'd0;
            end else begin
                o_kind  <= KIND_DRAINED;
                o_key   <= r_rkey[dsel];
                o_slot  <= 2'(dsel);
                o_count <= r_rcnt[dsel];
            end
        end
    end

endmodule
`default_nettype wire
